FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the arithmetic interval encoder.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define AIE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define AIE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/aie_pkg.sv
// Package of the arithmetic interval encoder: payload structs, codes and constants.
// Depends on nothing.
`default_nettype none

package aie_pkg;

  localparam int FreqBits    = 16;
  localparam int PendBits    = 32;
  localparam int MaxResults  = 32;
  localparam int CfgBits     = 6;
  localparam int ApbDataBits = 32;
  localparam int ApbAddrBits = 3;

  localparam logic ReqEncode    = 1'b0;
  localparam logic ReqFinish    = 1'b1;

  localparam logic RegTotalFreq = 1'b0;
  localparam logic RegCoderBits = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [FreqBits-1:0] cum_low;
    logic [FreqBits-1:0] cum_high;
  } aie_req_t;

  typedef struct packed {
    logic                lead_bit;
    logic [PendBits-1:0] follow_count;
    logic                last;
  } aie_res_t;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StMulHi,
    StMulLo,
    StAddLo,
    StShift,
    StE3,
    StFinish
  } aie_state_e;

endpackage

`default_nettype wire

FILE: sv/arithmetic_interval_encoder_unit.sv
// Top level of the arithmetic interval encoder with E1/E2/E3 renormalisation.
// Depends on aie_pkg and assert_macros.svh.
`default_nettype none

// Each encode transfer carries the cumulative bounds of one symbol and is turned
// into zero or more result transfers, one per E1/E2 shift, each carrying the lead bit
// and the number of opposite bits that follow it; a finish transfer gives one closing
// result and restarts the coder. The block takes one request at a time. An encode is
// accepted, then runs the bit-serial divider of the range by the total frequency and
// the MulHi, MulLo and AddLo steps on the shared multiplier and adder. It then makes
// the E1/E2 shifts, stalling while results are not taken, and then the E3 shifts.
// A symbol with invalid bounds is dropped at acceptance, one whose range step comes
// out as zero leaves after the divider, and a finish waits while its result is not
// taken. Registers are to be written through the APB port only while idle; the block
// itself does not enforce this.

`include "assert_macros.svh"

module arithmetic_interval_encoder_unit import aie_pkg::*; #(
  parameter int STATE_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire aie_req_t               in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output aie_res_t                    out_data_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [ApbAddrBits-1:0] paddr,
  input  wire logic [ApbDataBits-1:0] pwdata,
  output logic      [ApbDataBits-1:0] prdata,
  output logic                        pready
);

  localparam int Rw   = STATE_BITS + 1;
  localparam int CntW = $clog2(Rw);
  localparam int NW   = $clog2(MaxResults + 1);
  localparam logic [CfgBits-1:0] MinBits = CfgBits'(4);
  localparam logic [CfgBits-1:0] MaxBits = CfgBits'(STATE_BITS + 1);
  localparam logic [CfgBits-1:0] ResetBits = CfgBits'(17);

  function automatic logic [CfgBits-1:0] eff_of(input logic [CfgBits-1:0] b);
    logic [CfgBits-1:0] e;
    e = b;
    if (b < MinBits) begin
      e = MinBits;
    end else if (b > MaxBits) begin
      e = MaxBits;
    end
    return e;
  endfunction

  function automatic logic [STATE_BITS-1:0] top_of(input logic [CfgBits-1:0] e);
    logic [Rw-1:0] t;
    t = (Rw'(1) << (e - CfgBits'(1))) - Rw'(1);
    return t[STATE_BITS-1:0];
  endfunction

  aie_state_e             state_q, state_d;
  logic [FreqBits-1:0]    total_q, total_d;
  logic [CfgBits-1:0]     bits_q, bits_d;
  logic [STATE_BITS-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [PendBits-1:0]    pend_q, pend_d;
  logic [FreqBits-1:0]    cl_q, cl_d, ch_q, ch_d;
  logic [Rw-1:0]          quot_q, quot_d;
  logic [FreqBits-1:0]    rem_q, rem_d;
  logic [CntW-1:0]        dcnt_q, dcnt_d;
  logic [Rw-1:0]          prod_q, prod_d;
  logic [NW-1:0]          n_q, n_d;
  logic                   out_valid_q, out_valid_d;
  aie_res_t               out_q, out_d;

  logic [CfgBits-1:0]     eff;
  logic [STATE_BITS-1:0]  top, half, q1, q3;
  logic [STATE_BITS-1:0]  base, sh_lo, sh_hi;
  logic                   is_e1, e12_now, e3_now, e12_next, cont, out_free, cfg_wr;
  logic [FreqBits:0]      div_sh;
  logic                   div_ge;
  logic [FreqBits-1:0]    mul_op;
  logic [Rw-1:0]          mul_res;
  logic [PendBits-1:0]    pend_inc;

  assign eff  = eff_of(bits_q);
  assign top  = top_of(eff);
  assign half = STATE_BITS'(1) << (eff - CfgBits'(2));
  assign q1   = STATE_BITS'(1) << (eff - CfgBits'(3));
  assign q3   = half + q1;

  // Shared shift unit for E1, E2 and E3 steps.
  assign is_e1    = hi_q < half;
  assign e12_now  = is_e1 || (lo_q >= half);
  assign e3_now   = (lo_q >= q1) && (hi_q < q3);
  assign base     = (state_q == StE3) ? q1 : (is_e1 ? '0 : half);
  assign sh_lo    = (lo_q - base) << 1;
  assign sh_hi    = ((hi_q - base) << 1) | STATE_BITS'(1);
  assign e12_next = (sh_hi < half) || (sh_lo >= half);
  assign cont     = (n_q < NW'(MaxResults - 1)) && e12_next;

  // Restoring divider, one quotient bit a cycle.
  assign div_sh = {rem_q, quot_q[Rw-1]};
  assign div_ge = div_sh >= {1'b0, total_q};

  // Shared multiplier; the product never exceeds the range, so Rw bits suffice.
  assign mul_op  = (state_q == StMulHi) ? ch_q : cl_q;
  assign mul_res = Rw'(quot_q * Rw'(mul_op));

  assign pend_inc = (pend_q == '1) ? pend_q : pend_q + PendBits'(1);
  assign out_free = !out_valid_q || out_ready_i;
  assign cfg_wr   = psel && penable && pwrite && pready;

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    bits_d      = bits_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pend_d      = pend_q;
    cl_d        = cl_q;
    ch_d        = ch_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    prod_d      = prod_q;
    n_d         = n_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    in_ready_o  = 1'b0;

    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cl_d = in_data_i.cum_low;
          ch_d = in_data_i.cum_high;
          if (in_data_i.req_type == ReqFinish) begin
            state_d = StFinish;
          end else if (!(total_q == '0 || in_data_i.cum_low >= in_data_i.cum_high ||
                         in_data_i.cum_high > total_q)) begin
            quot_d  = {1'b0, hi_q} - {1'b0, lo_q} + Rw'(1);
            rem_d   = '0;
            dcnt_d  = CntW'(Rw - 1);
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        rem_d  = div_ge ? FreqBits'(div_sh - {1'b0, total_q}) : div_sh[FreqBits-1:0];
        quot_d = {quot_q[Rw-2:0], div_ge};
        if (dcnt_q == '0) begin
          state_d = StMulHi;
        end else begin
          dcnt_d = dcnt_q - CntW'(1);
        end
      end
      StMulHi: begin
        if (quot_q == '0) begin
          state_d = StIdle;
        end else begin
          prod_d  = mul_res;
          state_d = StMulLo;
        end
      end
      StMulLo: begin
        hi_d    = STATE_BITS'({1'b0, lo_q} + prod_q - Rw'(1));
        prod_d  = mul_res;
        state_d = StAddLo;
      end
      StAddLo: begin
        lo_d    = STATE_BITS'({1'b0, lo_q} + prod_q);
        n_d     = '0;
        state_d = StShift;
      end
      StShift: begin
        if (!e12_now || n_q == NW'(MaxResults)) begin
          state_d = StE3;
        end else if (out_free) begin
          lo_d               = sh_lo;
          hi_d               = sh_hi;
          out_d.lead_bit     = !is_e1;
          out_d.follow_count = pend_q;
          out_d.last         = !cont;
          out_valid_d        = 1'b1;
          pend_d             = '0;
          n_d                = n_q + NW'(1);
        end
      end
      StE3: begin
        if (e3_now) begin
          lo_d   = sh_lo;
          hi_d   = sh_hi;
          pend_d = pend_inc;
        end else begin
          state_d = StIdle;
        end
      end
      StFinish: begin
        if (out_free) begin
          out_d.lead_bit     = lo_q >= q1;
          out_d.follow_count = pend_inc;
          out_d.last         = 1'b1;
          out_valid_d        = 1'b1;
          lo_d               = '0;
          hi_d               = top;
          pend_d             = '0;
          state_d            = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (cfg_wr) begin
      if (paddr[2] == RegTotalFreq) begin
        total_d = pwdata[FreqBits-1:0];
      end else begin
        bits_d = pwdata[CfgBits-1:0];
        lo_d   = '0;
        hi_d   = top_of(eff_of(pwdata[CfgBits-1:0]));
        pend_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      total_q     <= FreqBits'(1);
      bits_q      <= ResetBits;
      lo_q        <= '0;
      hi_q        <= top_of(eff_of(ResetBits));
      pend_q      <= '0;
      dcnt_q      <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      bits_q      <= bits_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      pend_q      <= pend_d;
      dcnt_q      <= dcnt_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cl_q   <= cl_d;
    ch_q   <= ch_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == RegCoderBits) ? ApbDataBits'(bits_q)
                                                  : ApbDataBits'(total_q);

  `AIE_ASSERT(a_interval_ordered, lo_q <= hi_q, "Interval low exceeds interval high.")
  `AIE_ASSERT(a_interval_in_range, hi_q <= top, "Interval high exceeds the coder top.")
  `AIE_ASSERT_ALWAYS(a_shift_count_bound, !rst_ni || (n_q <= NW'(MaxResults)), "Too many shifts.")

endmodule

`default_nettype wire

FILE: tb/sv/arithmetic_interval_encoder_unit_test.sv
// Testbench of the arithmetic interval encoder: directed and random symbol transfers,
// with an encoder predictor, result checking, APB register writes and random stalls.
// Depends on aie_pkg and the arithmetic_interval_encoder_unit RTL.
`timescale 1ns / 1ps

module arithmetic_interval_encoder_unit_test;
  import aie_pkg::*;

  localparam int StateBits  = 32;
  localparam int QuietTail  = 300;
  localparam int PhaseCount = 8;
  localparam int PhaseItems = 29;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  aie_req_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  aie_res_t               out_data;
  logic                   psel      = 1'b0;
  logic                   penable   = 1'b0;
  logic                   pwrite    = 1'b0;
  logic [ApbAddrBits-1:0] paddr     = '0;
  logic [ApbDataBits-1:0] pwdata    = '0;
  logic [ApbDataBits-1:0] prdata;
  logic                   pready;

  aie_req_t    request_queue[$];
  aie_res_t    coded_bits_due[$];
  int          failures     = 0;
  int          send_gap     = 0;
  int          take_gap     = 0;
  bit          send_steady  = 1'b0;
  bit          recv_steady  = 1'b0;

  logic [15:0] freq_total;
  logic [5:0]  precision_raw;
  logic [63:0] coder_low;
  logic [63:0] coder_high;
  logic [31:0] e3_pending;

  arithmetic_interval_encoder_unit #(
    .STATE_BITS(StateBits)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(30_000_000);
    $display("Verification failed");
    $finish;
  end

  function automatic logic [63:0] interval_top();
    int eff;
    eff = precision_raw;
    if (eff < 4) eff = 4;
    if (eff > StateBits + 1) eff = StateBits + 1;
    return (64'd1 << (eff - 1)) - 64'd1;
  endfunction

  function automatic void restart_interval();
    coder_low  = '0;
    coder_high = interval_top();
    e3_pending = '0;
  endfunction

  // Narrows the interval for an encode and queues its renormalisation bits; a finish closes.
  function automatic void encode_request(input aie_req_t req);
    logic [63:0] top, half, q1, q3, lo, hi, span, slice;
    aie_res_t    res;
    aie_res_t    fresh[$];
    int          e3;
    top  = interval_top();
    half = (top + 64'd1) >> 1;
    q1   = half >> 1;
    q3   = q1 * 64'd3;
    lo   = coder_low;
    hi   = coder_high;
    if (req.req_type == ReqFinish) begin
      res.lead_bit     = (lo < q1) ? 1'b0 : 1'b1;
      res.follow_count = (e3_pending == '1) ? e3_pending : e3_pending + 32'd1;
      res.last         = 1'b1;
      coded_bits_due.push_back(res);
      restart_interval();
      return;
    end
    if (freq_total == 16'd0 || req.cum_low >= req.cum_high || req.cum_high > freq_total) return;
    span  = hi - lo + 64'd1;
    slice = span / freq_total;
    if (slice == 64'd0) return;
    hi = lo + slice * req.cum_high - 64'd1;
    lo = lo + slice * req.cum_low;
    while (fresh.size() < MaxResults && (hi < half || lo >= half)) begin
      res.follow_count = e3_pending;
      res.last         = 1'b0;
      if (hi < half) begin
        res.lead_bit = 1'b0;
        lo = lo << 1;
        hi = (hi << 1) + 64'd1;
      end else begin
        res.lead_bit = 1'b1;
        lo = (lo - half) << 1;
        hi = ((hi - half) << 1) + 64'd1;
      end
      fresh.push_back(res);
      e3_pending = '0;
    end
    for (e3 = 0; e3 < 64 && lo >= q1 && hi < q3; e3++) begin
      lo = (lo - q1) << 1;
      hi = ((hi - q1) << 1) + 64'd1;
      if (e3_pending != '1) e3_pending = e3_pending + 32'd1;
    end
    coder_low  = lo;
    coder_high = hi;
    if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    foreach (fresh[k]) coded_bits_due.push_back(fresh[k]);
  endfunction

  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  task automatic report_error(input string what);
    failures++;
    if (failures <= 100) $display("ERROR at %0t: %s", $time, what);
  endtask

  task automatic check_result(input aie_res_t got);
    aie_res_t want;
    if (coded_bits_due.size() == 0) begin
      report_error($sformatf("result with nothing outstanding: lead %0b follow %0d last %0b",
                             got.lead_bit, got.follow_count, got.last));
      return;
    end
    want = coded_bits_due.pop_front();
    if (got.lead_bit !== want.lead_bit)
      report_error($sformatf("lead_bit %0b, expected %0b", got.lead_bit, want.lead_bit));
    if (got.follow_count !== want.follow_count)
      report_error($sformatf("follow_count %0d, expected %0d",
                             got.follow_count, want.follow_count));
    if (got.last !== want.last)
      report_error($sformatf("last %0b, expected %0b", got.last, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) encode_request(in_data);
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (request_queue.size() > 0) begin
        in_data  <= request_queue.pop_front();
        in_valid <= 1'b1;
        send_gap <= pick_gap(send_steady);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      out_ready <= 1'b0;
      take_gap  <= 0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (take_gap > 0) begin
        out_ready <= 1'b0;
        take_gap  <= take_gap - 1;
      end else begin
        g = pick_gap(recv_steady);
        out_ready <= (g == 0);
        take_gap  <= (g > 0) ? g - 1 : 0;
      end
    end
  end

  task automatic write_register(input logic index, input logic [ApbDataBits-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (index == RegTotalFreq) begin
      freq_total = value[15:0];
    end else begin
      precision_raw = value[5:0];
      restart_interval();
    end
  endtask

  task automatic queue_request(input logic kind, input int low_bound, input int high_bound);
    aie_req_t r;
    r.req_type = kind;
    r.cum_low  = low_bound[15:0];
    r.cum_high = high_bound[15:0];
    request_queue.push_back(r);
  endtask

  // Waits at falling edges until every request has been taken and every result has come.
  task automatic settle(input int tail);
    @(negedge clk);
    while (request_queue.size() != 0 || in_valid || coded_bits_due.size() != 0)
      @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  initial begin : stimulus
    int phase, k, r, eff, raw, limit, tf, lo_b, hi_b;
    freq_total    = 16'd1;
    precision_raw = 6'd17;
    restart_interval();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_request(ReqEncode, 0, 1);
    queue_request(ReqEncode, 0, 0);
    queue_request(ReqEncode, 0, 2);
    queue_request(ReqFinish, 0, 0);
    settle(QuietTail);

    write_register(RegTotalFreq, 32'd16384);
    @(negedge clk);
    queue_request(ReqEncode, 0, 1);
    queue_request(ReqEncode, 16383, 16384);
    queue_request(ReqEncode, 8191, 8193);
    queue_request(ReqEncode, 0, 16384);
    queue_request(ReqEncode, 5, 3);
    queue_request(ReqFinish, 0, 0);
    settle(QuietTail);

    write_register(RegCoderBits, 32'd33);
    write_register(RegTotalFreq, 32'd65535);
    @(negedge clk);
    queue_request(ReqEncode, 65534, 65535);
    queue_request(ReqEncode, 0, 1);
    queue_request(ReqEncode, 32767, 32768);
    queue_request(ReqEncode, 65535, 65535);
    queue_request(ReqFinish, 65535, 65535);
    settle(QuietTail);

    write_register(RegCoderBits, 32'd4);
    write_register(RegTotalFreq, 32'd2);
    @(negedge clk);
    queue_request(ReqEncode, 0, 1);
    queue_request(ReqEncode, 1, 2);
    queue_request(ReqEncode, 0, 2);
    queue_request(ReqFinish, 0, 0);
    settle(QuietTail);

    write_register(RegTotalFreq, 32'd65535);
    @(negedge clk);
    queue_request(ReqEncode, 0, 65535);
    queue_request(ReqFinish, 0, 0);
    settle(QuietTail);

    write_register(RegTotalFreq, 32'd0);
    write_register(RegCoderBits, 32'd0);
    @(negedge clk);
    queue_request(ReqEncode, 0, 1);
    queue_request(ReqFinish, 0, 0);
    settle(QuietTail);

    write_register(RegTotalFreq, 32'd65535);
    write_register(RegCoderBits, 32'd63);
    @(negedge clk);
    queue_request(ReqEncode, 100, 200);
    queue_request(ReqFinish, 0, 0);
    settle(QuietTail);

    for (phase = 0; phase < PhaseCount; phase++) begin
      if (phase == 0) eff = 4;
      else if (phase == 1) eff = StateBits + 1;
      else eff = $urandom_range(5, StateBits);
      raw = eff;
      if (eff == 4 && $urandom_range(0, 1) == 1) raw = $urandom_range(0, 3);
      if (eff == StateBits + 1 && $urandom_range(0, 1) == 1) raw = $urandom_range(34, 63);
      limit = (eff >= 19) ? 65535 : (1 << (eff - 3));
      tf    = (phase % 3 == 0) ? limit : $urandom_range(1, limit);
      write_register(RegCoderBits, raw);
      write_register(RegTotalFreq, tf);
      @(negedge clk);
      send_steady = (phase == 2);
      recv_steady = (phase == 2 || phase == 5);
      for (k = 0; k < PhaseItems; k++) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          queue_request(ReqFinish, $urandom_range(0, 65535), $urandom_range(0, 65535));
        end else if (r < 14) begin
          queue_request(ReqEncode, $urandom_range(0, 65535), $urandom_range(0, 65535));
        end else if (r < 40) begin
          lo_b = $urandom_range(0, tf - 1);
          queue_request(ReqEncode, lo_b, lo_b + 1);
        end else begin
          hi_b = $urandom_range(1, tf);
          lo_b = $urandom_range(0, hi_b - 1);
          queue_request(ReqEncode, lo_b, hi_b);
        end
        if (k == PhaseItems / 2) settle(0);
      end
      settle(QuietTail);
    end

    send_steady = 1'b0;
    recv_steady = 1'b0;
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
